[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define BPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// Bit packer package
// Widths, item kind codes, control structs and CRC byte-update functions.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int FIELD_W            = 64;
    localparam int COUNT_W            = 7;
    localparam int BYTE_W             = 8;
    localparam int BUF_W              = FIELD_W + BYTE_W;
    localparam int MAX_FIELD_BITS_DEF = 64;

    localparam logic [7:0]  CRC8_TAPS  = 8'h07;
    localparam logic [15:0] CRC16_TAPS = 16'h8005;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ALIGN = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic has_byte;
        logic last_byte;
        logic slot_free;
    } t_dp_status;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC8_TAPS) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC16_TAPS) : (c << 1);
        end
        return c;
    endfunction

endpackage

[design/bit_packer_with_crc8_crc16.sv]
// ----------------------------------------------------------------------------
// MSB-first bit packer with CRC-8 / CRC-16
// Packs fields into bytes and tags each byte with the running CRCs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  item    | in        | i_valid / o_stall  | i_kind, i_field_value, i_bit_count
//  byte    | out       | o_valid / i_stall  | o_out_byte, o_crc8_value,
//          |           |                    | o_crc16_value, o_last_of_item
//
// An item is loaded, then each byte it completes (up to eight) is emitted
// in turn; an item that yields no byte still passes through the emit state.
// Without stalls the rate is set by the single byte-wide CRC update per cycle.
// Reset (synchronous, low) clears pending bits and both CRCs.
// A stalled output byte holds its register; the next byte waits behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bit_packer_with_crc8_crc16 #(
    parameter int MAX_FIELD_BITS = bpc_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_field_value,
    input  logic [6:0]  i_bit_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [7:0]  o_crc8_value,
    output logic [15:0] o_crc16_value,
    output logic        o_last_of_item
);
    import bpc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    bpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bpc_datapath #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_field_value  (i_field_value),
        .i_bit_count    (i_bit_count),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_crc8_value   (o_crc8_value),
        .o_crc16_value  (o_crc16_value),
        .o_last_of_item (o_last_of_item)
    );

    `BPC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "not busy")
    `BPC_ASSERT_SAME(a_idle_no_byte, i_clk, i_rst_n, !o_stall, !status.has_byte, "byte left")
    `BPC_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, cmd.emit, o_valid, "byte not shown")

endmodule

[design/bpc_ctrl.sv]
// ----------------------------------------------------------------------------
// Bit packer controller
// Takes one item at a time, then steps the datapath through its bytes.
// ----------------------------------------------------------------------------
module bpc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bpc_pkg::t_dp_status i_status,
    output bpc_pkg::t_dp_cmd    o_cmd
);
    import bpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_status.has_byte) begin
                    n_state = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/bpc_datapath.sv]
// ----------------------------------------------------------------------------
// Bit packer datapath
// Bit buffer, byte extraction, running CRC-8/CRC-16 and output register.
// ----------------------------------------------------------------------------
module bpc_datapath #(
    parameter int MAX_FIELD_BITS = bpc_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_kind,
    input  logic [63:0]          i_field_value,
    input  logic [6:0]           i_bit_count,
    input  bpc_pkg::t_dp_cmd     i_cmd,
    output bpc_pkg::t_dp_status  o_status,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [7:0]           o_out_byte,
    output logic [7:0]           o_crc8_value,
    output logic [15:0]          o_crc16_value,
    output logic                 o_last_of_item
);
    import bpc_pkg::*;

    // buffer holds the stream left-aligned; bits below r_total are zero
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [COUNT_W-1:0] r_total, n_total;
    logic [7:0]         r_crc8, n_crc8;
    logic [15:0]        r_crc16, n_crc16;
    logic               r_valid;
    logic [7:0]         r_out_byte;
    logic [7:0]         r_out_crc8;
    logic [15:0]        r_out_crc16;
    logic               r_out_last;

    logic [COUNT_W-1:0] nbits;
    logic [FIELD_W-1:0] val_l;
    logic [BUF_W-1:0]   merged;
    logic [7:0]         cur_byte;
    logic [7:0]         crc8_upd;
    logic [15:0]        crc16_upd;

    assign nbits    = (i_bit_count > COUNT_W'(MAX_FIELD_BITS)) ?
                      COUNT_W'(MAX_FIELD_BITS) : i_bit_count;
    assign val_l    = i_field_value << (COUNT_W'(FIELD_W) - nbits);
    assign merged   = r_buf | ({val_l, 8'h00} >> r_total[2:0]);
    assign cur_byte = r_buf[BUF_W-1 -: BYTE_W];
    assign crc8_upd  = crc8_byte(r_crc8, cur_byte);
    assign crc16_upd = crc16_byte(r_crc16, cur_byte);

    always_comb begin
        n_buf   = r_buf;
        n_total = r_total;
        n_crc8  = r_crc8;
        n_crc16 = r_crc16;
        if (i_cmd.load) begin
            unique case (i_kind)
                KIND_WRITE: begin
                    if (nbits != '0) begin
                        n_buf   = merged;
                        n_total = r_total + nbits;
                    end
                end
                KIND_ALIGN: begin
                    if (r_total != '0) begin
                        n_total = COUNT_W'(BYTE_W);
                    end
                end
                KIND_CLEAR: begin
                    n_crc8  = '0;
                    n_crc16 = '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.emit) begin
            n_buf   = r_buf << BYTE_W;
            n_total = r_total - COUNT_W'(BYTE_W);
            n_crc8  = crc8_upd;
            n_crc16 = crc16_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_total <= '0;
            r_crc8  <= '0;
            r_crc16 <= '0;
            r_valid <= 1'b0;
        end else begin
            r_buf   <= n_buf;
            r_total <= n_total;
            r_crc8  <= n_crc8;
            r_crc16 <= n_crc16;
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte  <= cur_byte;
            r_out_crc8  <= crc8_upd;
            r_out_crc16 <= crc16_upd;
            r_out_last  <= (r_total < COUNT_W'(2 * BYTE_W));
        end
    end

    assign o_valid            = r_valid;
    assign o_out_byte         = r_out_byte;
    assign o_crc8_value       = r_out_crc8;
    assign o_crc16_value      = r_out_crc16;
    assign o_last_of_item     = r_out_last;
    assign o_status.has_byte  = (r_total >= COUNT_W'(BYTE_W));
    assign o_status.last_byte = (r_total < COUNT_W'(2 * BYTE_W));
    assign o_status.slot_free = !r_valid || !i_stall;

endmodule

[verif/bpc_byte_checker.sv]
// ----------------------------------------------------------------------------
// Bit packer byte checker
// Watches the item and byte channels. Each item transfer is run through a
// local model of the packer and CRCs, and each byte transfer is compared
// with the oldest predicted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bpc_byte_checker #(
    parameter int MAX_BITS = bpc_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  logic        i_item_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_field_value,
    input  logic [6:0]  i_bit_count,
    input  logic        i_byte_valid,
    input  logic        i_byte_stall,
    input  logic [7:0]  i_out_byte,
    input  logic [7:0]  i_crc8_value,
    input  logic [15:0] i_crc16_value,
    input  logic        i_last_of_item,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_bytes_seen
);
    import bpc_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  crc8;
        logic [15:0] crc16;
        logic        last;
    } t_tagged_byte;

    t_tagged_byte expected_bytes[$];

    logic [6:0]  held_bits;
    logic [2:0]  held_count;
    logic [7:0]  crc8_acc;
    logic [15:0] crc16_acc;
    int          mismatch_count;
    int          byte_count;

    // Bitwise, MSB-first, no reflection
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ d[i];
            c  = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0} ^ (fb ? 16'h8005 : 16'h0000);
        end
        return c;
    endfunction

    task automatic append_bit(input logic b, inout int produced);
        logic [7:0]   full;
        t_tagged_byte entry;
        if (held_count == 3'd7) begin
            full      = {held_bits, b};
            crc8_acc  = crc8_update(crc8_acc, full);
            crc16_acc = crc16_update(crc16_acc, full);
            entry     = '{full, crc8_acc, crc16_acc, 1'b0};
            expected_bytes.insert(expected_bytes.size(), entry);
            produced++;
            held_bits  = '0;
            held_count = '0;
        end else begin
            held_bits  = {held_bits[5:0], b};
            held_count = held_count + 3'd1;
        end
    endtask

    task automatic pack_item(input logic [1:0] kind, input logic [63:0] value,
                             input logic [6:0] count);
        int           n;
        int           produced;
        t_tagged_byte tail;
        produced = 0;
        case (kind)
            KIND_WRITE: begin
                n = (int'(count) > MAX_BITS) ? MAX_BITS : int'(count);
                for (int i = n - 1; i >= 0; i--) append_bit(value[i], produced);
            end
            KIND_ALIGN: begin
                while (held_count != 3'd0) append_bit(1'b0, produced);
            end
            KIND_CLEAR: begin
                crc8_acc  = '0;
                crc16_acc = '0;
            end
            default: ;
        endcase
        if (produced > 0) begin
            tail      = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.insert(expected_bytes.size(), tail);
        end
    endtask

    always @(posedge i_clk) begin
        t_tagged_byte want;
        t_tagged_byte got;
        if (!i_rst_n) begin
            held_bits      = '0;
            held_count     = '0;
            crc8_acc       = '0;
            crc16_acc      = '0;
            mismatch_count = 0;
            byte_count     = 0;
            expected_bytes.delete();
        end else begin
            // bytes out belong to items already taken, so check first
            if (i_byte_valid && !i_byte_stall) begin
                got = '{i_out_byte, i_crc8_value, i_crc16_value, i_last_of_item};
                byte_count++;
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected byte %02h crc8 %02h crc16 %04h last %0b",
                                 $time, got.data, got.crc8, got.crc16, got.last);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"[%0t] byte %0d mismatch: exp byte %02h crc8 %02h ",
                                      "crc16 %04h last %0b, got byte %02h crc8 %02h ",
                                      "crc16 %04h last %0b"},
                                     $time, byte_count, want.data, want.crc8, want.crc16,
                                     want.last, got.data, got.crc8, got.crc16, got.last);
                    end
                end
            end
            if (i_item_valid && !i_item_stall)
                pack_item(i_kind, i_field_value, i_bit_count);
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_bytes.size();
        o_bytes_seen  <= byte_count;
    end

endmodule

[verif/bit_packer_with_crc8_crc16_test.sv]
// ----------------------------------------------------------------------------
// Bit packer with CRC-8 / CRC-16 testbench
// Drives directed then random item transfers in bursts, stalls the byte
// channel on a varying pattern with one long hold-off, and lets the byte
// checker predict and compare every output byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bit_packer_with_crc8_crc16_test;
    import bpc_pkg::*;

    localparam int         TARGET_ITEMS = 400;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 20;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [63:0] i_field_value;
    logic [6:0]  i_bit_count;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic [7:0]  o_crc8_value;
    logic [15:0] o_crc16_value;
    logic        o_last_of_item;

    int mismatches;
    int outstanding;
    int bytes_seen;
    int items_sent;
    int cycle_count;
    bit hold_done;

    always #4 i_clk = ~i_clk;

    bit_packer_with_crc8_crc16 DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_field_value  (i_field_value),
        .i_bit_count    (i_bit_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_crc8_value   (o_crc8_value),
        .o_crc16_value  (o_crc16_value),
        .o_last_of_item (o_last_of_item)
    );

    bpc_byte_checker byte_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_valid),
        .i_item_stall   (o_stall),
        .i_kind         (i_kind),
        .i_field_value  (i_field_value),
        .i_bit_count    (i_bit_count),
        .i_byte_valid   (o_valid),
        .i_byte_stall   (i_stall),
        .i_out_byte     (o_out_byte),
        .i_crc8_value   (o_crc8_value),
        .i_crc16_value  (o_crc16_value),
        .i_last_of_item (o_last_of_item),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_bytes_seen   (bytes_seen)
    );

    // valid stays high on return; the caller lowers it for a gap
    task automatic send_item(input logic [1:0] kind, input logic [63:0] value,
                             input logic [6:0] count);
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_field_value <= value;
        i_bit_count   <= count;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // mostly writes of random width; ignored items do not count
    task automatic send_random_item(output bit counted);
        int          pick;
        logic [1:0]  kind;
        logic [63:0] value;
        logic [6:0]  count;
        pick    = $urandom_range(0, 99);
        value   = {$urandom, $urandom};
        count   = 7'($urandom_range(0, 127));
        kind    = KIND_WRITE;
        counted = 1'b1;
        if (pick < 30) begin
            count = 7'($urandom_range(1, 8));
        end else if (pick < 60) begin
            count = 7'($urandom_range(9, 64));
        end else if (pick < 66) begin
            count = 7'd64;
        end else if (pick < 78) begin
            kind = KIND_ALIGN;
        end else if (pick < 86) begin
            kind = KIND_CLEAR;
        end else if (pick < 91) begin
            kind    = KIND_UNUSED;
            counted = 1'b0;
        end else if (pick < 95) begin
            count   = 7'd0;
            counted = 1'b0;
        end else begin
            count = 7'($urandom_range(65, 127));
        end
        send_item(kind, value, count);
    endtask

    initial begin
        int effective;
        int burst;
        bit counted;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_kind        <= KIND_WRITE;
        i_field_value <= '0;
        i_bit_count   <= '0;
        items_sent     = 0;
        effective      = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(KIND_WRITE, 64'h1, 7'd1);
        send_item(KIND_WRITE, 64'h7F, 7'd7);
        send_item(KIND_WRITE, 64'h5, 7'd3);
        send_item(KIND_ALIGN, '0, '0);
        send_item(KIND_ALIGN, '1, '1);              // already aligned
        send_item(KIND_WRITE, '1, 7'd64);
        send_item(KIND_WRITE, '0, 7'd64);
        send_item(KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFA5, 7'd8);
        send_item(KIND_WRITE, '1, 7'd0);
        send_item(KIND_WRITE, {$urandom, $urandom}, 7'd127);
        send_item(KIND_WRITE, 64'h8000_0000_0000_0001, 7'd65);
        send_item(KIND_WRITE, 64'h1F, 7'd5);
        send_item(KIND_CLEAR, '1, 7'd5);            // pending bits survive
        send_item(KIND_WRITE, '0, 7'd3);
        send_item(KIND_UNUSED, '1, 7'd64);
        send_item(KIND_WRITE, 64'hC, 7'd4);
        send_item(KIND_CLEAR, '0, '0);
        send_item(KIND_ALIGN, '0, 7'd1);
        send_item(KIND_WRITE, 64'h0123_4567_89AB_CDEF, 7'd64);
        send_item(KIND_ALIGN, '0, '0);
        send_item(KIND_CLEAR, '0, '0);
        idle_gap(3);

        while (effective < TARGET_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
            repeat (burst) begin
                send_random_item(counted);
                if (counted) effective++;
            end
            idle_gap($urandom_range(1, 6));
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d item transfers (%0d directed), checked %0d byte transfers,",
                 items_sent, 21, bytes_seen);
        $display("with bursty input, varied output stalls and a %0d-cycle hold-off.",
                 LONG_HOLD);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // byte side: segments of no stall, random stall and periodic stall
    initial begin
        int mode;
        int seg_len;
        int phase;
        i_stall  <= 1'b0;
        hold_done = 1'b0;
        phase     = 0;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 80);
            repeat (seg_len) begin
                @(posedge i_clk);
                phase++;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 1) == 0);
                    2: i_stall <= ($urandom_range(0, 4) == 0);
                    default: i_stall <= (phase % 3 == 0);
                endcase
            end
            if (!hold_done && items_sent >= 120) begin
                @(posedge i_clk);
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

[filelist.f]
+incdir+design
design/bpc_pkg.sv
design/bpc_ctrl.sv
design/bpc_datapath.sv
design/bit_packer_with_crc8_crc16.sv
verif/bpc_byte_checker.sv
verif/bit_packer_with_crc8_crc16_test.sv
